### design/bbtc_pkg.sv
// Shared codes and constants for the bang-bang thermal controller.
// Holds drive codes, status codes, register indexes, reset values and the result struct.
// No dependencies.
package bbtc_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned HystWidth    = 12;
  localparam int unsigned DwellWidth   = 16;
  localparam int unsigned ErrWidth     = 8;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned DriveWidth   = 2;
  localparam int unsigned StatusWidth  = 3;

  localparam logic [CfgIdxWidth-1:0] RegRequestMax = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegRequestMin = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegAbortMax   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegAbortMin   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegHysteresis = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegMinDwell   = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegMaxErrors  = 3'd6;

  localparam int RequestMaxReset = 720;
  localparam int RequestMinReset = 0;
  localparam int AbortMaxReset   = 800;
  localparam int AbortMinReset   = -80;
  localparam logic [HystWidth-1:0]  HysteresisReset = 12'd8;
  localparam logic [DwellWidth-1:0] MinDwellReset   = 16'd2000;
  localparam logic [ErrWidth-1:0]   MaxErrorsReset  = 8'd5;

  localparam logic [DriveWidth-1:0] DrvOff  = 2'd0;
  localparam logic [DriveWidth-1:0] DrvHeat = 2'd1;
  localparam logic [DriveWidth-1:0] DrvCool = 2'd2;

  localparam logic [StatusWidth-1:0] StOk          = 3'd0;
  localparam logic [StatusWidth-1:0] StEnableFault = 3'd1;
  localparam logic [StatusWidth-1:0] StRequestBad  = 3'd2;
  localparam logic [StatusWidth-1:0] StSensorFault = 3'd3;
  localparam logic [StatusWidth-1:0] StDriverFault = 3'd4;
  localparam logic [StatusWidth-1:0] StForcedOff   = 3'd5;

  localparam logic [ErrWidth-1:0] ErrSaturate = 8'hFF;

  typedef struct packed {
    logic                   drive_valid;
    logic [DriveWidth-1:0]  drive;
    logic [ErrWidth-1:0]    error_total;
    logic [StatusWidth-1:0] status;
  } result_t;

endpackage

### design/bbtc_cfg_regs.sv
// Configuration register file of the bang-bang thermal controller.
// Decodes the write channel into the seven limit and timing registers.
// Depends on bbtc_pkg.
module bbtc_cfg_regs #(
  parameter int unsigned TEMP_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [bbtc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [bbtc_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  output logic signed [TEMP_WIDTH-1:0]      request_max_o,
  output logic signed [TEMP_WIDTH-1:0]      request_min_o,
  output logic signed [TEMP_WIDTH-1:0]      abort_max_o,
  output logic signed [TEMP_WIDTH-1:0]      abort_min_o,
  output logic [bbtc_pkg::HystWidth-1:0]    hysteresis_o,
  output logic [bbtc_pkg::DwellWidth-1:0]   min_dwell_ms_o,
  output logic [bbtc_pkg::ErrWidth-1:0]     max_errors_o
);
  import bbtc_pkg::*;

  logic signed [TEMP_WIDTH-1:0] request_max_q, request_min_q, abort_max_q, abort_min_q;
  logic [HystWidth-1:0]  hysteresis_q;
  logic [DwellWidth-1:0] min_dwell_q;
  logic [ErrWidth-1:0]   max_errors_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      request_max_q <= TEMP_WIDTH'(RequestMaxReset);
      request_min_q <= TEMP_WIDTH'(RequestMinReset);
      abort_max_q   <= TEMP_WIDTH'(AbortMaxReset);
      abort_min_q   <= TEMP_WIDTH'(AbortMinReset);
      hysteresis_q  <= HysteresisReset;
      min_dwell_q   <= MinDwellReset;
      max_errors_q  <= MaxErrorsReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRequestMax: request_max_q <= cfg_wdata_i[TEMP_WIDTH-1:0];
        RegRequestMin: request_min_q <= cfg_wdata_i[TEMP_WIDTH-1:0];
        RegAbortMax:   abort_max_q   <= cfg_wdata_i[TEMP_WIDTH-1:0];
        RegAbortMin:   abort_min_q   <= cfg_wdata_i[TEMP_WIDTH-1:0];
        RegHysteresis: hysteresis_q  <= cfg_wdata_i[HystWidth-1:0];
        RegMinDwell:   min_dwell_q   <= cfg_wdata_i[DwellWidth-1:0];
        RegMaxErrors:  max_errors_q  <= cfg_wdata_i[ErrWidth-1:0];
        default: ;
      endcase
    end
  end

  assign request_max_o  = request_max_q;
  assign request_min_o  = request_min_q;
  assign abort_max_o    = abort_max_q;
  assign abort_min_o    = abort_min_q;
  assign hysteresis_o   = hysteresis_q;
  assign min_dwell_ms_o = min_dwell_q;
  assign max_errors_o   = max_errors_q;

endmodule

### design/bbtc_ctrl.sv
// Control decision and controller state of the bang-bang thermal controller.
// Computes one tick's result from a registered item and updates the state on advance.
// Depends on bbtc_pkg.
module bbtc_ctrl #(
  parameter int unsigned TEMP_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  logic                              enable_i,
  input  logic                              enable_ok_i,
  input  logic signed [TEMP_WIDTH-1:0]      request_temp_i,
  input  logic                              request_ok_i,
  input  logic signed [TEMP_WIDTH-1:0]      measured_temp_i,
  input  logic                              measured_ok_i,
  input  logic [bbtc_pkg::DriveWidth-1:0]   driver_state_i,
  input  logic                              driver_ok_i,
  input  logic [bbtc_pkg::TimeWidth-1:0]    now_ms_i,
  input  logic signed [TEMP_WIDTH-1:0]      request_max_i,
  input  logic signed [TEMP_WIDTH-1:0]      request_min_i,
  input  logic signed [TEMP_WIDTH-1:0]      abort_max_i,
  input  logic signed [TEMP_WIDTH-1:0]      abort_min_i,
  input  logic [bbtc_pkg::HystWidth-1:0]    hysteresis_i,
  input  logic [bbtc_pkg::DwellWidth-1:0]   min_dwell_ms_i,
  input  logic [bbtc_pkg::ErrWidth-1:0]     max_errors_i,
  output bbtc_pkg::result_t                 result_o
);
  import bbtc_pkg::*;

  localparam int unsigned DiffWidth =
      ((TEMP_WIDTH + 1 > HystWidth + 1) ? TEMP_WIDTH + 1 : HystWidth + 1) + 1;

  logic [DriveWidth-1:0] last_drive_q, last_drive_d;
  logic [TimeWidth-1:0]  last_change_q, last_change_d;
  logic                  first_change_q, first_change_d;
  logic [ErrWidth-1:0]   err_q, err_d;

  logic signed [DiffWidth-1:0] delta, hyst_s;
  logic [TimeWidth-1:0]        elapsed;
  logic                        out_of_range;
  logic [DriveWidth-1:0]       target;
  logic                        valid;
  logic [DriveWidth-1:0]       cmd;
  logic [StatusWidth-1:0]      status;

  assign delta = DiffWidth'(request_temp_i) - DiffWidth'(measured_temp_i);
  assign hyst_s = $signed(DiffWidth'(hysteresis_i));
  assign elapsed = now_ms_i - last_change_q;
  assign out_of_range = (request_temp_i > request_max_i) || (request_temp_i < request_min_i) ||
                        (measured_temp_i > abort_max_i) || (measured_temp_i < abort_min_i);

  always_comb begin
    if (delta >= hyst_s) begin
      target = DrvHeat;
    end else if (delta <= -hyst_s) begin
      target = DrvCool;
    end else begin
      target = DrvOff;
    end
  end

  always_comb begin
    err_d          = err_q;
    last_drive_d   = last_drive_q;
    last_change_d  = last_change_q;
    first_change_d = first_change_q;
    valid          = 1'b0;
    cmd            = DrvOff;
    status         = StOk;

    if (!enable_ok_i) begin
      if (err_d != ErrSaturate) err_d = err_d + 1'b1;
      status = StEnableFault;
    end

    if ((last_drive_d != DrvOff) &&
        ((enable_ok_i && !enable_i) || (err_d > max_errors_i))) begin
      if (!driver_ok_i || (driver_state_i != DrvOff)) begin
        valid = 1'b1;
        cmd   = DrvOff;
      end
      last_drive_d = DrvOff;
      err_d        = '0;
      status       = StForcedOff;
    end

    if (enable_i && enable_ok_i) begin
      if (!request_ok_i) begin
        if (err_d != ErrSaturate) err_d = err_d + 1'b1;
        status = StRequestBad;
      end else if (!measured_ok_i) begin
        if (err_d != ErrSaturate) err_d = err_d + 1'b1;
        status = StSensorFault;
      end else if (!driver_ok_i) begin
        if (err_d != ErrSaturate) err_d = err_d + 1'b1;
        status = StDriverFault;
      end else if (out_of_range) begin
        if ((last_drive_d != DrvOff) || (driver_state_i != DrvOff)) begin
          valid         = 1'b1;
          cmd           = DrvOff;
          last_drive_d  = DrvOff;
          last_change_d = now_ms_i;
        end
        err_d  = '0;
        status = StForcedOff;
      end else begin
        if ((first_change_q || (elapsed > TimeWidth'(min_dwell_ms_i))) &&
            ((last_drive_d != target) || (driver_state_i != target))) begin
          valid          = 1'b1;
          cmd            = target;
          last_drive_d   = target;
          last_change_d  = now_ms_i;
          first_change_d = 1'b0;
        end
        err_d  = '0;
        status = StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_drive_q   <= DrvOff;
      last_change_q  <= '0;
      first_change_q <= 1'b1;
      err_q          <= '0;
    end else if (advance_i) begin
      last_drive_q   <= last_drive_d;
      last_change_q  <= last_change_d;
      first_change_q <= first_change_d;
      err_q          <= err_d;
    end
  end

  assign result_o.drive_valid = valid;
  assign result_o.drive       = valid ? cmd : last_drive_d;
  assign result_o.error_total = err_d;
  assign result_o.status      = status;

endmodule

### design/bang_bang_thermal_controller_core.sv
// Top level of the bang-bang thermal controller.
// Holds the input item register and the result register around the control decision.
// Depends on bbtc_pkg, bbtc_cfg_regs and bbtc_ctrl.
//
// Each input item is one control tick with the enable, request, measurement and
// driver report plus a millisecond timestamp. Each item yields exactly one result
// item with the drive command, its valid flag, the error count and a status code.
// Items enter through in_valid_i/in_ready_o and results leave through
// out_valid_o/out_ready_i. Items are registered and, while results are taken, the
// block takes one item per cycle: the item register feeds the decision logic, which
// writes the controller state and the result register in the same cycle.
// When the receiver stalls, the result register holds and the item register still
// accepts one more item; after that in_ready_o drops until the result is taken.
// Configuration writes use cfg_valid_i/cfg_ready_o and are always taken; they
// must only be issued while no item is in flight. Reset clears the controller
// state to drive off, no change yet and zero errors, and loads the default limits.
module bang_bang_thermal_controller_core #(
  parameter int unsigned TEMP_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bbtc_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [bbtc_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                enable_i,
  input  logic                                enable_ok_i,
  input  logic signed [TEMP_WIDTH-1:0]        request_temp_i,
  input  logic                                request_ok_i,
  input  logic signed [TEMP_WIDTH-1:0]        measured_temp_i,
  input  logic                                measured_ok_i,
  input  logic [bbtc_pkg::DriveWidth-1:0]     driver_state_i,
  input  logic                                driver_ok_i,
  input  logic [bbtc_pkg::TimeWidth-1:0]      now_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                drive_valid_o,
  output logic [bbtc_pkg::DriveWidth-1:0]     drive_o,
  output logic [bbtc_pkg::ErrWidth-1:0]       error_total_o,
  output logic [bbtc_pkg::StatusWidth-1:0]    status_o
);
  import bbtc_pkg::*;

  logic signed [TEMP_WIDTH-1:0] request_max, request_min, abort_max, abort_min;
  logic [HystWidth-1:0]  hysteresis;
  logic [DwellWidth-1:0] min_dwell_ms;
  logic [ErrWidth-1:0]   max_errors;

  logic                         in_valid_q, in_valid_d;
  logic                         enable_q, enable_ok_q, request_ok_q, measured_ok_q, driver_ok_q;
  logic signed [TEMP_WIDTH-1:0] request_temp_q, measured_temp_q;
  logic [DriveWidth-1:0]        driver_state_q;
  logic [TimeWidth-1:0]         now_ms_q;

  logic    out_valid_q, out_valid_d;
  result_t result_q, result_d;
  logic    advance, in_fire;

  assign cfg_ready_o = 1'b1;

  bbtc_cfg_regs #(
    .TEMP_WIDTH(TEMP_WIDTH)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .request_max_o  (request_max),
    .request_min_o  (request_min),
    .abort_max_o    (abort_max),
    .abort_min_o    (abort_min),
    .hysteresis_o   (hysteresis),
    .min_dwell_ms_o (min_dwell_ms),
    .max_errors_o   (max_errors)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      enable_q        <= enable_i;
      enable_ok_q     <= enable_ok_i;
      request_temp_q  <= request_temp_i;
      request_ok_q    <= request_ok_i;
      measured_temp_q <= measured_temp_i;
      measured_ok_q   <= measured_ok_i;
      driver_state_q  <= driver_state_i;
      driver_ok_q     <= driver_ok_i;
      now_ms_q        <= now_ms_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  bbtc_ctrl #(
    .TEMP_WIDTH(TEMP_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .enable_i        (enable_q),
    .enable_ok_i     (enable_ok_q),
    .request_temp_i  (request_temp_q),
    .request_ok_i    (request_ok_q),
    .measured_temp_i (measured_temp_q),
    .measured_ok_i   (measured_ok_q),
    .driver_state_i  (driver_state_q),
    .driver_ok_i     (driver_ok_q),
    .now_ms_i        (now_ms_q),
    .request_max_i   (request_max),
    .request_min_i   (request_min),
    .abort_max_i     (abort_max),
    .abort_min_i     (abort_min),
    .hysteresis_i    (hysteresis),
    .min_dwell_ms_i  (min_dwell_ms),
    .max_errors_i    (max_errors),
    .result_o        (result_d)
  );

  assign out_valid_o   = out_valid_q;
  assign drive_valid_o = result_q.drive_valid;
  assign drive_o       = result_q.drive;
  assign error_total_o = result_q.error_total;
  assign status_o      = result_q.status;

endmodule
